@@ rtl/cca_pkg.sv @@
`default_nettype none

package cca_pkg;

    // Field widths of the stream and configuration payloads
    localparam int FUNC_W    = 2;
    localparam int ROW_W     = 7;
    localparam int COL_W     = 7;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;

    // Operation codes carried on the input beat
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT  = 2'd2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = 8'd128;
    localparam logic [CFG_W-1:0] GRID_HEIGHT_RESET = 8'd128;
    localparam logic [CFG_W-1:0] PASS_COUNT_RESET  = 8'd4;

    // Smoothing rule: a wall survives with four or more wall neighbours,
    // a floor cell turns to wall with five or more.
    localparam logic [3:0] WALL_KEEP_MIN  = 4'd4;
    localparam logic [3:0] FLOOR_FILL_MIN = 4'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_ABOVE,
        ST_CUR,
        ST_SWEEP
    } cca_state_t;

    // Row address choice for the store read port
    typedef enum logic [2:0] {
        RD_CELL,
        RD_ZERO,
        RD_ONE,
        RD_NEXT,
        RD_SKIP
    } rd_sel_t;

    // Source of a store write
    typedef enum logic [1:0] {
        WR_NONE,
        WR_CLEAR,
        WR_CELL,
        WR_ROW
    } wr_sel_t;

    // Update of the two row registers of the sweep window
    typedef enum logic [1:0] {
        ROW_HOLD,
        ROW_LOAD_ABOVE,
        ROW_LOAD_CUR,
        ROW_SHIFT
    } row_op_t;

    typedef enum logic [1:0] {
        OUT_DONE,
        OUT_RANGE,
        OUT_CELL
    } out_sel_t;

    typedef struct packed {
        logic     rd_en;
        rd_sel_t  rd_sel;
        wr_sel_t  wr_sel;
        row_op_t  row_op;
        logic     clr_step;
        logic     cap_cell;
        logic     y_init;
        logic     y_step;
        logic     pass_init;
        logic     pass_step;
        logic     out_load;
        out_sel_t out_sel;
    } cca_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
        logic out_of_range;
        logic run_empty;
        logic row_last;
        logic pass_last;
    } cca_status_t;

endpackage

`default_nettype wire

@@ rtl/cca_datapath.sv @@
`default_nettype none

module cca_datapath #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [cca_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cca_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic [cca_pkg::ROW_W-1:0]     in_row,
    input  wire logic [cca_pkg::COL_W-1:0]     in_col,
    input  wire logic                          in_wall,
    input  wire logic                          out_ready,
    input  wire cca_pkg::cca_cmd_t             cmd,
    output cca_pkg::cca_status_t               status,
    output logic                               out_valid,
    output logic                               wall_out,
    output logic                               out_status
);
    import cca_pkg::*;

    localparam int AW  = $clog2(MAX_HEIGHT);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int HW  = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
    localparam int WW  = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

    // Eight-input wall count for one cell
    function automatic logic [3:0] count_walls(input logic [7:0] nbr);
        logic [3:0] sum;
        sum = '0;
        for (int i = 0; i < 8; i++)
        begin
            sum = sum + {3'b000, nbr[i]};
        end
        return sum;
    endfunction

    // Cell store: one row per word
    logic [MAX_WIDTH-1:0] mem [MAX_HEIGHT];

    logic [CFG_W-1:0]     grid_width_reg;
    logic [CFG_W-1:0]     grid_height_reg;
    logic [CFG_W-1:0]     pass_count_reg;
    logic [HW-1:0]        h_eff;
    logic [WW-1:0]        w_eff;

    logic [AW+ROW_W-1:0]  row_wide;
    logic [CW+COL_W-1:0]  col_wide;
    logic [AW-1:0]        in_row_idx;
    logic [CW-1:0]        in_col_idx;

    logic [AW-1:0]        clr_idx_reg;
    logic [AW-1:0]        y_reg;
    logic [AW:0]          y_inc1;
    logic [AW:0]          y_inc2;
    logic [CFG_W-1:0]     pass_cnt_reg;

    logic [AW-1:0]        cell_row_reg;
    logic [CW-1:0]        cell_col_reg;
    logic                 cell_wall_reg;

    logic [AW-1:0]        rd_addr;
    logic [MAX_WIDTH-1:0] rd_data_reg;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [MAX_WIDTH-1:0] wr_data;
    logic [MAX_WIDTH-1:0] cell_row_data;

    logic [MAX_WIDTH-1:0] above_reg;
    logic [MAX_WIDTH-1:0] cur_reg;
    logic [MAX_WIDTH-1:0] next_row;

    logic                 out_valid_reg;
    logic                 wall_out_reg;
    logic                 out_status_reg;
    logic                 wall_out_next;
    logic                 out_status_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_height_reg <= GRID_HEIGHT_RESET;
            pass_count_reg  <= PASS_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                REG_PASS_COUNT:  pass_count_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Grid size saturated to the store dimensions
    always_comb
    begin
        h_eff = (HW'(grid_height_reg) > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(grid_height_reg);
        w_eff = (WW'(grid_width_reg) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(grid_width_reg);
    end

    // Input coordinates as store indexes
    assign row_wide   = {{AW{1'b0}}, in_row};
    assign col_wide   = {{CW{1'b0}}, in_col};
    assign in_row_idx = row_wide[AW-1:0];
    assign in_col_idx = col_wide[CW-1:0];

    assign y_inc1 = {1'b0, y_reg} + (AW+1)'(1);
    assign y_inc2 = {1'b0, y_reg} + (AW+1)'(2);

    // Status towards the controller
    always_comb
    begin
        status.clr_last     = (clr_idx_reg == AW'(MAX_HEIGHT - 1));
        status.out_free     = !out_valid_reg || out_ready;
        status.out_of_range = (HW'(in_row) >= h_eff) || (WW'(in_col) >= w_eff);
        status.run_empty    = (w_eff < WW'(3)) || (h_eff < HW'(3)) || (pass_count_reg == '0);
        status.row_last     = (HW'(y_reg) == (h_eff - HW'(2)));
        status.pass_last    = (pass_cnt_reg == (pass_count_reg - CFG_W'(1)));
    end

    // Clearing pointer, row pointer and pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            y_reg        <= '0;
            pass_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
            if (cmd.y_init)
            begin
                y_reg <= AW'(1);
            end
            else if (cmd.y_step)
            begin
                y_reg <= y_inc1[AW-1:0];
            end
            if (cmd.pass_init)
            begin
                pass_cnt_reg <= '0;
            end
            else if (cmd.pass_step)
            begin
                pass_cnt_reg <= pass_cnt_reg + CFG_W'(1);
            end
        end
    end

    // Coordinates of a single-cell access, held until its write or read completes
    always_ff @(posedge clk)
    begin
        if (cmd.cap_cell)
        begin
            cell_row_reg  <= in_row_idx;
            cell_col_reg  <= in_col_idx;
            cell_wall_reg <= in_wall;
        end
    end

    // Read address selection
    always_comb
    begin
        case (cmd.rd_sel)
            RD_CELL: rd_addr = in_row_idx;
            RD_ZERO: rd_addr = '0;
            RD_ONE:  rd_addr = AW'(1);
            RD_NEXT: rd_addr = y_inc1[AW-1:0];
            RD_SKIP: rd_addr = y_inc2[AW-1:0];
            default: rd_addr = '0;
        endcase
    end

    // Cell write merges the new bit into the row just read
    always_comb
    begin
        cell_row_data               = rd_data_reg;
        cell_row_data[cell_col_reg] = cell_wall_reg;
    end

    // Write port selection
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = '0;
        wr_data = '1;
        case (cmd.wr_sel)
            WR_CLEAR:
            begin
                wr_addr = clr_idx_reg;
                wr_data = '1;
            end
            WR_CELL:
            begin
                wr_addr = cell_row_reg;
                wr_data = cell_row_data;
            end
            WR_ROW:
            begin
                wr_addr = y_reg;
                wr_data = next_row;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Store with one registered read port and one write port
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Window rows: previous generation of the row above and of the current row
    always_ff @(posedge clk)
    begin
        case (cmd.row_op)
            ROW_LOAD_ABOVE: above_reg <= rd_data_reg;
            ROW_LOAD_CUR:   cur_reg   <= rd_data_reg;
            ROW_SHIFT:
            begin
                above_reg <= cur_reg;
                cur_reg   <= rd_data_reg;
            end
            default: ;
        endcase
    end

    // One lane per interior column; the row below is the word just read
    assign next_row[0]           = cur_reg[0];
    assign next_row[MAX_WIDTH-1] = cur_reg[MAX_WIDTH-1];

    for (genvar x = 1; x < MAX_WIDTH - 1; x++)
    begin : g_lane
        logic [7:0] nbr;
        logic [3:0] cnt;
        logic       wall_new;

        assign nbr = {above_reg[x-1], above_reg[x], above_reg[x+1],
                      cur_reg[x-1], cur_reg[x+1],
                      rd_data_reg[x-1], rd_data_reg[x], rd_data_reg[x+1]};
        assign cnt = count_walls(nbr);
        assign wall_new = cur_reg[x] ? (cnt >= WALL_KEEP_MIN) : (cnt >= FLOOR_FILL_MIN);
        // Columns at or past the right border keep their value
        assign next_row[x] = (WW'(x + 1) < w_eff) ? wall_new : cur_reg[x];
    end

    // Result value selection
    always_comb
    begin
        case (cmd.out_sel)
            OUT_RANGE:
            begin
                wall_out_next   = 1'b0;
                out_status_next = 1'b1;
            end
            OUT_CELL:
            begin
                wall_out_next   = rd_data_reg[cell_col_reg];
                out_status_next = 1'b0;
            end
            default:
            begin
                wall_out_next   = 1'b0;
                out_status_next = 1'b0;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            wall_out_reg   <= wall_out_next;
            out_status_reg <= out_status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign wall_out   = wall_out_reg;
    assign out_status = out_status_reg;

endmodule

`default_nettype wire

@@ rtl/cca_ctrl.sv @@
`default_nettype none

module cca_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [cca_pkg::FUNC_W-1:0] in_func,
    input  wire cca_pkg::cca_status_t       status,
    output logic                            in_ready,
    output cca_pkg::cca_cmd_t               cmd
);
    import cca_pkg::*;

    cca_state_t state_reg;
    cca_state_t state_next;
    logic       accept;

    // State register; reset starts the clearing pass over the store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE) && status.out_free;
    assign accept   = in_valid && in_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.wr_sel   = WR_CLEAR;
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_func)
                        FUNC_WRITE, FUNC_READ:
                        begin
                            if (status.out_of_range)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = OUT_RANGE;
                            end
                            else
                            begin
                                cmd.rd_en    = 1'b1;
                                cmd.rd_sel   = RD_CELL;
                                cmd.cap_cell = 1'b1;
                                state_next   = (in_func == FUNC_WRITE) ? ST_WRITE : ST_READ;
                            end
                        end
                        FUNC_RUN:
                        begin
                            if (status.run_empty)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_sel  = OUT_DONE;
                            end
                            else
                            begin
                                cmd.rd_en     = 1'b1;
                                cmd.rd_sel    = RD_ZERO;
                                cmd.pass_init = 1'b1;
                                state_next    = ST_ABOVE;
                            end
                        end
                        default:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_sel  = OUT_DONE;
                        end
                    endcase
                end
            end
            ST_WRITE:
            begin
                cmd.wr_sel   = WR_CELL;
                cmd.out_load = 1'b1;
                cmd.out_sel  = OUT_DONE;
                state_next   = ST_IDLE;
            end
            ST_READ:
            begin
                cmd.out_load = 1'b1;
                cmd.out_sel  = OUT_CELL;
                state_next   = ST_IDLE;
            end
            ST_ABOVE:
            begin
                // Top border row arrives; fetch row one
                cmd.row_op = ROW_LOAD_ABOVE;
                cmd.y_init = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_ONE;
                state_next = ST_CUR;
            end
            ST_CUR:
            begin
                cmd.row_op = ROW_LOAD_CUR;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_NEXT;
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                // Row below is present: write the new row and slide the window
                cmd.wr_sel = WR_ROW;
                cmd.row_op = ROW_SHIFT;
                if (!status.row_last)
                begin
                    cmd.y_step = 1'b1;
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_SKIP;
                end
                else if (status.pass_last)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_DONE;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.pass_step = 1'b1;
                    cmd.rd_en     = 1'b1;
                    cmd.rd_sel    = RD_ZERO;
                    state_next    = ST_ABOVE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/cave_cellular_automaton.sv @@
`default_nettype none

// Cave smoothing engine over a wall/floor grid of up to MAX_HEIGHT rows by
// MAX_WIDTH columns, kept as one row per word in a single-port-read,
// single-port-write store. After reset the block fills the store with wall,
// one row at a time, and accepts no beat meanwhile; configuration writes
// are taken at any time. A cell write or read first reads the row, then
// merges the new bit or selects the bit; an access outside the grid, a run
// that has nothing to do, or an unused code is answered from the idle state
// without a store access. Each pass of a run fetches two rows, then updates
// one whole row per cycle, all columns in parallel, limited by one row read
// and one row write per cycle at the store. Every input beat gives exactly
// one result beat; the result register lets a new beat in on the cycle its
// predecessor is taken.
module cave_cellular_automaton #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // row[6:0], col[13:7], wall_in[14], zero[15]
    input  wire logic [1:0]  s_axis_tuser,   // func[1:0]

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // wall_out[0], zero[7:1]
    output logic [0:0]       m_axis_tuser,   // status[0]

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import cca_pkg::*;

    cca_cmd_t    cmd;
    cca_status_t status;
    logic        wall_out;
    logic        out_status;

    assign cfg_ready = 1'b1;

    cca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_func  (s_axis_tuser),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    cca_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_row     (s_axis_tdata[6:0]),
        .in_col     (s_axis_tdata[13:7]),
        .in_wall    (s_axis_tdata[14]),
        .out_ready  (m_axis_tready),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (m_axis_tvalid),
        .wall_out   (wall_out),
        .out_status (out_status)
    );

    // Result beat packing
    assign m_axis_tdata = {7'b0000000, wall_out};
    assign m_axis_tuser = out_status;

endmodule

`default_nettype wire

@@ dv/tb_cave_cellular_automaton.sv @@
`default_nettype none

module tb_cave_cellular_automaton;

    import cca_pkg::*;

    // Grid size of the instance and the depth of its cell map
    localparam int MAP_W = 128;
    localparam int MAP_H = 128;

    // The one operation code that the package leaves unnamed
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int HOLD_CYCLES   = 64;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 20;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int CALM_ITEMS    = 180;
    localparam int CYCLE_LIMIT   = 1500000;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              wall;
    } cave_op_t;

    typedef struct packed {
        logic wall_out;
        logic status;
    } cave_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    // Shadow copy of the grid and of the configuration registers
    logic [MAP_W-1:0] cave_map [MAP_H];
    logic [CFG_W-1:0] cfg_width;
    logic [CFG_W-1:0] cfg_height;
    logic [CFG_W-1:0] cfg_passes;

    cave_result_t pending_results [$];
    int           error_count;
    int           items_sent;
    int           send_quiet;
    logic         calm_phase;
    logic         hold_request;

    cave_cellular_automaton #(
        .MAX_WIDTH  (MAP_W),
        .MAX_HEIGHT (MAP_H)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply the configured number of smoothing generations to the shadow grid.
    // Each generation reads only the previous one, border cells stay put.
    function automatic void smooth_generations(int w, int h);
        logic [MAP_W-1:0] prev [MAP_H];
        int               n;
        if (w < 3 || h < 3)
            return;
        for (int p = 0; p < cfg_passes; p++)
        begin
            prev = cave_map;
            for (int y = 1; y < h - 1; y++)
            begin
                for (int x = 1; x < w - 1; x++)
                begin
                    n = 0;
                    for (int dy = -1; dy <= 1; dy++)
                    begin
                        for (int dx = -1; dx <= 1; dx++)
                        begin
                            if (dy != 0 || dx != 0)
                                n += int'(prev[y + dy][x + dx]);
                        end
                    end
                    if (prev[y][x] && n <= 3)
                        cave_map[y][x] = 1'b0;
                    else if (!prev[y][x] && n >= 5)
                        cave_map[y][x] = 1'b1;
                end
            end
        end
    endfunction

    // Work out the result beat of one operation and update the shadow grid.
    function automatic cave_result_t predict_cell_op(cave_op_t op);
        cave_result_t res;
        int           w;
        int           h;
        res = '0;
        w = (cfg_width > MAP_W) ? MAP_W : int'(cfg_width);
        h = (cfg_height > MAP_H) ? MAP_H : int'(cfg_height);
        case (op.func)
            FUNC_WRITE, FUNC_READ:
            begin
                if (op.row >= h || op.col >= w)
                    res.status = 1'b1;
                else if (op.func == FUNC_WRITE)
                    cave_map[op.row][op.col] = op.wall;
                else
                    res.wall_out = cave_map[op.row][op.col];
            end
            FUNC_RUN:
                smooth_generations(w, h);
            default:
                ;
        endcase
        return res;
    endfunction

    // Offer one operation beat, with an occasional burst of idle cycles first,
    // and record its expected result once the block has taken it.
    task automatic send_cell_op(input logic [FUNC_W-1:0] func, input logic [ROW_W-1:0] row,
                                input logic [COL_W-1:0] col, input logic wall);
        cave_op_t op;
        int       pick;
        op.func = func;
        op.row  = row;
        op.col  = col;
        op.wall = wall;
        if (!calm_phase)
        begin
            if (send_quiet > 0)
                send_quiet--;
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
                else if (pick == 2)
                    send_quiet = $urandom_range(10, 40);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, op.wall, op.col, op.row};
        s_axis_tuser  <= op.func;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(predict_cell_op(op));
        items_sent++;
    endtask

    // Stop offering beats and wait until every result has come back.
    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        wait_until_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:  cfg_width  = val;
            REG_GRID_HEIGHT: cfg_height = val;
            REG_PASS_COUNT:  cfg_passes = val;
            default:         ;
        endcase
    endtask

    task automatic set_grid(input int w, input int h, input int passes);
        write_cfg_reg(REG_GRID_WIDTH, w[7:0]);
        write_cfg_reg(REG_GRID_HEIGHT, h[7:0]);
        write_cfg_reg(REG_PASS_COUNT, passes[7:0]);
    endtask

    // Out-of-place accesses and unused codes mixed into the well-formed traffic
    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_cell_op(FUNC_UNUSED, ROW_W'($urandom_range(0, 127)),
                            COL_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
            1: send_cell_op(FUNC_READ, ROW_W'($urandom_range(0, 127)),
                            COL_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
            default: send_cell_op(FUNC_WRITE, ROW_W'($urandom_range(0, 127)),
                                  COL_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        endcase
    endtask

    // Every cell starts as wall after the clearing pass.
    task automatic test_after_reset();
        send_cell_op(FUNC_READ, 7'd0, 7'd0, 1'b0);
        send_cell_op(FUNC_READ, 7'd127, 7'd127, 1'b0);
        send_cell_op(FUNC_READ, 7'd0, 7'd127, 1'b1);
    endtask

    // Single cell writes and reads, and the unused function code.
    task automatic test_cell_access();
        send_cell_op(FUNC_WRITE, 7'd127, 7'd127, 1'b0);
        send_cell_op(FUNC_READ, 7'd127, 7'd127, 1'b1);
        send_cell_op(FUNC_WRITE, 7'd64, 7'd33, 1'b0);
        send_cell_op(FUNC_WRITE, 7'd64, 7'd33, 1'b1);
        send_cell_op(FUNC_READ, 7'd64, 7'd33, 1'b0);
        send_cell_op(FUNC_UNUSED, 7'd127, 7'd127, 1'b1);
    endtask

    // A run with the reset configuration fills lone floor cells again.
    task automatic test_default_run();
        send_cell_op(FUNC_WRITE, 7'd5, 7'd5, 1'b0);
        send_cell_op(FUNC_RUN, 7'd127, 7'd127, 1'b1);
        send_cell_op(FUNC_READ, 7'd5, 7'd5, 1'b0);
    endtask

    // The receiver holds off for a long stretch while beats keep coming.
    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            if (i % 2 == 0)
                send_cell_op(FUNC_WRITE, ROW_W'($urandom_range(0, 127)),
                             COL_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
            else
                send_cell_op(FUNC_READ, ROW_W'($urandom_range(0, 127)),
                             COL_W'($urandom_range(0, 127)), 1'b0);
        end
    endtask

    // Oversized, undersized and smallest grids, no passes and the most passes.
    task automatic test_grid_limits();
        set_grid(255, 200, 1);
        send_cell_op(FUNC_READ, 7'd127, 7'd127, 1'b0);
        set_grid(2, 2, 3);
        send_cell_op(FUNC_READ, 7'd1, 7'd1, 1'b0);
        send_cell_op(FUNC_READ, 7'd2, 7'd0, 1'b0);
        send_cell_op(FUNC_WRITE, 7'd0, 7'd2, 1'b0);
        send_cell_op(FUNC_RUN, 7'd0, 7'd0, 1'b0);
        set_grid(3, 3, 255);
        send_cell_op(FUNC_WRITE, 7'd1, 7'd1, 1'b0);
        send_cell_op(FUNC_RUN, 7'd3, 7'd3, 1'b0);
        send_cell_op(FUNC_READ, 7'd1, 7'd1, 1'b0);
        write_cfg_reg(REG_PASS_COUNT, 8'd0);
        send_cell_op(FUNC_WRITE, 7'd1, 7'd1, 1'b0);
        send_cell_op(FUNC_RUN, 7'd1, 7'd1, 1'b1);
        send_cell_op(FUNC_READ, 7'd1, 7'd1, 1'b0);
        set_grid(128, 10, 255);
        send_cell_op(FUNC_WRITE, 7'd4, 7'd126, 1'b0);
        send_cell_op(FUNC_RUN, 7'd0, 7'd0, 1'b0);
        send_cell_op(FUNC_READ, 7'd4, 7'd126, 1'b0);
    endtask

    // One random scene: fill a corner of a random grid, smooth it, read it back.
    task automatic random_scene();
        int w;
        int h;
        int passes;
        int fill_w;
        int fill_h;
        int density;
        int pick;
        pick = $urandom_range(0, 9);
        w = (pick == 0) ? $urandom_range(0, 2) : (pick == 1) ? $urandom_range(15, 255)
                                                              : $urandom_range(3, 14);
        pick = $urandom_range(0, 9);
        h = (pick == 0) ? $urandom_range(0, 2) : (pick == 1) ? $urandom_range(15, 255)
                                                              : $urandom_range(3, 14);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            passes = 0;
        else if (pick == 1)
            passes = (h <= 16) ? $urandom_range(100, 255) : $urandom_range(6, 12);
        else
            passes = $urandom_range(1, 5);
        set_grid(w, h, passes);

        fill_w  = (w > 12) ? 12 : w;
        fill_h  = (h > 12) ? 12 : h;
        density = $urandom_range(20, 80);
        for (int r = 0; r < fill_h; r++)
        begin
            for (int c = 0; c < fill_w; c++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_noise();
                send_cell_op(FUNC_WRITE, ROW_W'(r), COL_W'(c),
                             $urandom_range(1, 100) <= density);
            end
        end
        send_cell_op(FUNC_RUN, ROW_W'($urandom_range(0, 127)), COL_W'($urandom_range(0, 127)),
                     1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0)
            send_cell_op(FUNC_RUN, ROW_W'($urandom_range(0, 127)),
                         COL_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        for (int r = 0; r <= fill_h; r++)
        begin
            for (int c = 0; c <= fill_w; c++)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_noise();
                send_cell_op(FUNC_READ, ROW_W'(r), COL_W'(c), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic test_random();
        int first_item;
        first_item = items_sent;
        while (items_sent < first_item + RANDOM_ITEMS)
        begin
            if (items_sent >= first_item + RANDOM_ITEMS - CALM_ITEMS)
                calm_phase = 1'b1;
            random_scene();
        end
    endtask

    // Result receiver: random stall bursts, quiet stretches and the long hold-off
    initial
    begin
        int gap_left;
        int hold_left;
        int quiet_left;
        int pick;
        gap_left      = 0;
        hold_left     = 0;
        quiet_left    = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                m_axis_tready <= 1'b0;
            end
            else if (quiet_left > 0 || calm_phase)
            begin
                if (quiet_left > 0)
                    quiet_left--;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 7);
                if (pick < 2)
                begin
                    gap_left = $urandom_range(1, 6) - 1;
                    m_axis_tready <= 1'b0;
                end
                else
                begin
                    if (pick == 2)
                        quiet_left = $urandom_range(20, 80);
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        cave_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no expectation: wall_out %0d, status %0d",
                       m_axis_tdata[0], m_axis_tuser[0]);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[0] !== want.wall_out)
                begin
                    $error("wall_out mismatch: expected %0d, actual %0d",
                           want.wall_out, m_axis_tdata[0]);
                    error_count++;
                end
                if (m_axis_tuser[0] !== want.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, m_axis_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        error_count   = 0;
        items_sent    = 0;
        send_quiet    = 0;
        calm_phase    = 1'b0;
        hold_request  = 1'b0;
        for (int r = 0; r < MAP_H; r++)
            cave_map[r] = '1;
        cfg_width  = GRID_WIDTH_RESET;
        cfg_height = GRID_HEIGHT_RESET;
        cfg_passes = PASS_COUNT_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_cell_access();
        test_default_run();
        test_backpressure();
        test_grid_limits();
        test_random();

        wait_until_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
